### sv/bvm_pkg.sv
// shared types and constants for the battery low-voltage monitor
// no dependencies; imported by every module of the block
package bvm_pkg;

   localparam int CELL_W     = 13;
   localparam int SUM_OUT_W  = 15;
   localparam int CNT_W      = 16;
   localparam int ERR_THR_W  = 4;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = {SUM_OUT_W{1'b1}};
   localparam logic [CNT_W-1:0]     CNT_MAX     = {CNT_W{1'b1}};

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRACKING_ENABLE  = 2'd0,
      CSR_LOW_POWER_ENABLE = 2'd1,
      CSR_LOW_THRESHOLD_MV = 2'd2,
      CSR_ERROR_THRESHOLD  = 2'd3
   } csr_index_type;

   localparam logic                 RST_TRACKING_ENABLE  = 1'b0;
   localparam logic                 RST_LOW_POWER_ENABLE = 1'b0;
   localparam logic [CELL_W-1:0]    RST_LOW_THRESHOLD_MV = 13'd3300;
   localparam logic [ERR_THR_W-1:0] RST_ERROR_THRESHOLD  = 4'd3;

   // per-transaction commands to each cell lane
   typedef struct packed {
      logic update;
      logic refill;
   } lane_ctrl_type;

endpackage

### sv/bvm_cell_lane.sv
// one cell lane: sliding sample window, running sum and low-threshold compare
// depends on bvm_pkg
module bvm_cell_lane #(
   parameter int WINDOW_DEPTH = 4,
   parameter int NOMINAL_MV   = 3800
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  bvm_pkg::lane_ctrl_type                             ctrl,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]                    pos,
   input  logic [bvm_pkg::CELL_W-1:0]                         sample_mv,
   input  logic [bvm_pkg::CELL_W-1:0]                         low_threshold_mv,
   output logic [bvm_pkg::CELL_W+$clog2(WINDOW_DEPTH)-1:0]    sum_next,
   output logic                                               low
);
   import bvm_pkg::*;

   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W = CELL_W + POS_W;
   localparam logic [CELL_W-1:0] NOMINAL  = CELL_W'(NOMINAL_MV);
   localparam logic [SUM_W-1:0]  FULL_SUM = SUM_W'(WINDOW_DEPTH * NOMINAL_MV);

   logic [CELL_W-1:0] window_ff [WINDOW_DEPTH];
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  limit;

   always_comb begin
      priority if (ctrl.refill) begin
         sum_in = FULL_SUM;
      end else if (ctrl.update) begin
         // the oldest sample is part of the sum, so this never goes negative
         sum_in = sum_ff + SUM_W'(sample_mv) - SUM_W'(window_ff[pos]);
      end else begin
         sum_in = sum_ff;
      end
   end

   assign limit    = SUM_W'(low_threshold_mv) * SUM_W'(WINDOW_DEPTH);
   assign sum_next = sum_in;
   assign low      = (sum_in < limit);

   always_ff @(posedge clock) begin
      if (reset || ctrl.refill) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            window_ff[k] <= NOMINAL;
         end
      end else if (ctrl.update) begin
         window_ff[pos] <= sample_mv;
      end
      if (reset) begin
         sum_ff <= FULL_SUM;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

### sv/bvm_err_track.sv
// saturating counter of consecutive error samples and persistent-error compare
// depends on bvm_pkg
module bvm_err_track (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic                              sample_error,
   input  logic [bvm_pkg::ERR_THR_W-1:0]     error_threshold,
   output logic [bvm_pkg::CNT_W-1:0]         count_next,
   output logic                              at_threshold
);
   import bvm_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      priority if (!update) begin
         count_in = count_ff;
      end else if (!sample_error) begin
         count_in = '0;
      end else if (count_ff == CNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // count+1 formed one bit wider so a full counter still meets the threshold
   assign at_threshold = ({1'b0, count_in} + (CNT_W+1)'(1)) >= (CNT_W+1)'(error_threshold);
   assign count_next   = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### sv/bvm_rsp_stage.sv
// merge stage: combines lane results, gates flags and holds the response register
// depends on bvm_pkg
module bvm_rsp_stage #(
   parameter int SUM_W = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           track,
   input  logic                           low_power,
   input  logic                           low0,
   input  logic                           low1,
   input  logic                           at_threshold,
   input  logic [bvm_pkg::CNT_W-1:0]      count,
   input  logic [SUM_W-1:0]               sum0,
   input  logic [SUM_W-1:0]               sum1,
   output logic                           busy,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_low_voltage,
   output logic                           rsp_in_error,
   output logic [bvm_pkg::CNT_W-1:0]      rsp_error_count,
   output logic [bvm_pkg::SUM_OUT_W-1:0]  rsp_cell0_sum,
   output logic [bvm_pkg::SUM_OUT_W-1:0]  rsp_cell1_sum
);
   import bvm_pkg::*;

   localparam int EXT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 low_voltage_ff;
   logic                 in_error_ff;
   logic [CNT_W-1:0]     error_count_ff;
   logic [SUM_OUT_W-1:0] cell0_sum_ff;
   logic [SUM_OUT_W-1:0] cell1_sum_ff;
   logic [EXT_W-1:0]     sum0_ext;
   logic [EXT_W-1:0]     sum1_ext;
   logic [SUM_OUT_W-1:0] sum0_sat;
   logic [SUM_OUT_W-1:0] sum1_sat;

   assign sum0_ext = EXT_W'(sum0);
   assign sum1_ext = EXT_W'(sum1);
   assign sum0_sat = (sum0_ext > EXT_W'(SUM_OUT_MAX)) ? SUM_OUT_MAX : sum0_ext[SUM_OUT_W-1:0];
   assign sum1_sat = (sum1_ext > EXT_W'(SUM_OUT_MAX)) ? SUM_OUT_MAX : sum1_ext[SUM_OUT_W-1:0];

   // a held response blocks the input only while the receiver stalls it
   assign busy         = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in = load || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         low_voltage_ff <= track && low_power && (low0 || low1);
         in_error_ff    <= track && at_threshold;
         error_count_ff <= count;
         cell0_sum_ff   <= sum0_sat;
         cell1_sum_ff   <= sum1_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_low_voltage = low_voltage_ff;
   assign rsp_in_error    = in_error_ff;
   assign rsp_error_count = error_count_ff;
   assign rsp_cell0_sum   = cell0_sum_ff;
   assign rsp_cell1_sum   = cell1_sum_ff;

endmodule

### sv/battery_low_voltage_monitor.sv
// top level of the battery low-voltage monitor: config registers, two cell lanes,
// error tracker and response stage; depends on bvm_pkg and all bvm_* modules
//
// usage:
//   req channel: one transaction per battery sample (kind = sample) or window
//   restart (kind = restart), taken when req_valid is high and req_stall is low.
//   rsp channel: exactly one transaction per request, in order, taken when
//   rsp_valid is high and rsp_stall is low.
//   csr channel: register writes by index (tracking enable, low-power enable,
//   low threshold, error threshold); csr_ready is always high. write only while
//   no request is in flight.
// response: registered; it appears in the cycle after its request is taken.
// throughput: one transaction per cycle unless a held response is stalled; both
//   cell lanes update their window and running sum in parallel in the accepting
//   cycle, and the response register takes the merged result in that same cycle.
// stall: a stalled response holds its register and raises req_stall; a new
//   request is taken in the cycle the held response leaves.
// reset: windows refill with the nominal voltage, sums to depth times nominal,
//   error count and window position clear, registers return to defaults.
module battery_low_voltage_monitor #(
   parameter int WINDOW_DEPTH = 4,
   parameter int NOMINAL_MV   = 3800
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [bvm_pkg::CELL_W-1:0]        req_cell0_mv,
   input  logic [bvm_pkg::CELL_W-1:0]        req_cell1_mv,
   input  logic                              req_sample_error,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_low_voltage,
   output logic                              rsp_in_error,
   output logic [bvm_pkg::CNT_W-1:0]         rsp_error_count,
   output logic [bvm_pkg::SUM_OUT_W-1:0]     rsp_cell0_sum,
   output logic [bvm_pkg::SUM_OUT_W-1:0]     rsp_cell1_sum,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bvm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bvm_pkg::*;

   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W = CELL_W + POS_W;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_DEPTH - 1);

   logic                 tracking_enable_ff;
   logic                 low_power_enable_ff;
   logic [CELL_W-1:0]    low_threshold_mv_ff;
   logic [ERR_THR_W-1:0] error_threshold_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     pos_in;

   logic                 accept;
   logic                 track;
   logic                 low_power;
   logic                 is_sample;
   lane_ctrl_type        lane_ctrl;
   logic                 err_update;
   logic                 busy;
   logic [SUM_W-1:0]     sum0;
   logic [SUM_W-1:0]     sum1;
   logic                 low0;
   logic                 low1;
   logic [CNT_W-1:0]     count;
   logic                 at_threshold;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_enable_ff  <= RST_TRACKING_ENABLE;
         low_power_enable_ff <= RST_LOW_POWER_ENABLE;
         low_threshold_mv_ff <= RST_LOW_THRESHOLD_MV;
         error_threshold_ff  <= RST_ERROR_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRACKING_ENABLE:  tracking_enable_ff  <= csr_data[0];
            CSR_LOW_POWER_ENABLE: low_power_enable_ff <= csr_data[0];
            CSR_LOW_THRESHOLD_MV: low_threshold_mv_ff <= csr_data[CELL_W-1:0];
            CSR_ERROR_THRESHOLD:  error_threshold_ff  <= csr_data[ERR_THR_W-1:0];
         endcase
      end
   end

   assign accept    = req_valid && !req_stall;
   assign track     = tracking_enable_ff;
   assign low_power = tracking_enable_ff && low_power_enable_ff;
   assign is_sample = (req_kind == KIND_SAMPLE);

   assign lane_ctrl.update = accept && is_sample && low_power;
   assign lane_ctrl.refill = accept && (req_kind == KIND_RESTART) && low_power;
   assign err_update       = accept && is_sample && track;

   // restart leaves the window position alone
   always_comb begin
      if (!lane_ctrl.update) begin
         pos_in = pos_ff;
      end else if (pos_ff == POS_LAST) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   bvm_cell_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .NOMINAL_MV   (NOMINAL_MV)
   ) u_lane0 (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (lane_ctrl),
      .pos              (pos_ff),
      .sample_mv        (req_cell0_mv),
      .low_threshold_mv (low_threshold_mv_ff),
      .sum_next         (sum0),
      .low              (low0)
   );

   bvm_cell_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .NOMINAL_MV   (NOMINAL_MV)
   ) u_lane1 (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (lane_ctrl),
      .pos              (pos_ff),
      .sample_mv        (req_cell1_mv),
      .low_threshold_mv (low_threshold_mv_ff),
      .sum_next         (sum1),
      .low              (low1)
   );

   bvm_err_track u_err (
      .clock           (clock),
      .reset           (reset),
      .update          (err_update),
      .sample_error    (req_sample_error),
      .error_threshold (error_threshold_ff),
      .count_next      (count),
      .at_threshold    (at_threshold)
   );

   bvm_rsp_stage #(
      .SUM_W (SUM_W)
   ) u_rsp (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .track           (track),
      .low_power       (low_power),
      .low0            (low0),
      .low1            (low1),
      .at_threshold    (at_threshold),
      .count           (count),
      .sum0            (sum0),
      .sum1            (sum1),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_low_voltage (rsp_low_voltage),
      .rsp_in_error    (rsp_in_error),
      .rsp_error_count (rsp_error_count),
      .rsp_cell0_sum   (rsp_cell0_sum),
      .rsp_cell1_sum   (rsp_cell1_sum)
   );

   assign req_stall = busy;

   // every accepted request yields a response in the next cycle
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after accepted request");

   // flags stay low while the monitor is disabled
   a_flags_off_when_disabled : assert property (@(posedge clock) disable iff (reset)
      (accept && !track) |=> (!rsp_low_voltage && !rsp_in_error))
      else $error("flag raised with tracking disabled");

   // low voltage needs low-power tracking
   a_low_needs_low_power : assert property (@(posedge clock) disable iff (reset)
      (accept && !low_power) |=> !rsp_low_voltage)
      else $error("low voltage flagged without low-power tracking");

   // window position stays within the window
   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("window position out of range");

endmodule

### tb/battery_low_voltage_monitor_test.sv
`timescale 1ns / 1ps
// self-checking testbench for battery_low_voltage_monitor: drives samples and restarts,
// predicts every response in a scoreboard class; depends on bvm_pkg and the block's rtl

typedef struct packed {
   logic                               low_voltage;
   logic                               in_error;
   logic [bvm_pkg::CNT_W-1:0]          error_count;
   logic [bvm_pkg::SUM_OUT_W-1:0]      cell0_sum;
   logic [bvm_pkg::SUM_OUT_W-1:0]      cell1_sum;
} battery_status_type;

class battery_scoreboard #(int DEPTH = 4, int NOMINAL = 3800);
   // register mirror
   bit                               tracking_on;
   bit                               low_power_on;
   logic [bvm_pkg::CELL_W-1:0]       low_mv;
   logic [bvm_pkg::ERR_THR_W-1:0]    err_thr;
   // block state mirror
   logic [bvm_pkg::CELL_W-1:0]       cell0_win[DEPTH];
   logic [bvm_pkg::CELL_W-1:0]       cell1_win[DEPTH];
   int unsigned                      cell0_total;
   int unsigned                      cell1_total;
   int unsigned                      slot;
   logic [bvm_pkg::CNT_W-1:0]        err_run;
   battery_status_type               expected_status_q[$];
   int                               failures;

   function new();
      failures = 0;
      reset_state();
   endfunction

   function void refill_windows();
      for (int k = 0; k < DEPTH; k++) begin
         cell0_win[k] = bvm_pkg::CELL_W'(NOMINAL);
         cell1_win[k] = bvm_pkg::CELL_W'(NOMINAL);
      end
      cell0_total = DEPTH * NOMINAL;
      cell1_total = DEPTH * NOMINAL;
   endfunction

   function void reset_state();
      tracking_on  = bvm_pkg::RST_TRACKING_ENABLE;
      low_power_on = bvm_pkg::RST_LOW_POWER_ENABLE;
      low_mv       = bvm_pkg::RST_LOW_THRESHOLD_MV;
      err_thr      = bvm_pkg::RST_ERROR_THRESHOLD;
      refill_windows();
      slot    = 0;
      err_run = '0;
   endfunction

   function void write_register(bvm_pkg::csr_index_type idx,
                                logic [bvm_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bvm_pkg::CSR_TRACKING_ENABLE:  tracking_on  = data[0];
         bvm_pkg::CSR_LOW_POWER_ENABLE: low_power_on = data[0];
         bvm_pkg::CSR_LOW_THRESHOLD_MV: low_mv       = data[bvm_pkg::CELL_W-1:0];
         bvm_pkg::CSR_ERROR_THRESHOLD:  err_thr      = data[bvm_pkg::ERR_THR_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_status_q.size();
   endfunction

   // advance the mirrored state by one accepted transaction and queue its status
   function void note_sample(logic kind, logic [bvm_pkg::CELL_W-1:0] c0,
                             logic [bvm_pkg::CELL_W-1:0] c1, logic err);
      bit                 track;
      bit                 lp;
      int unsigned        limit;
      battery_status_type want;
      track = tracking_on;
      lp    = track && low_power_on;
      if (kind == bvm_pkg::KIND_RESTART) begin
         if (lp) refill_windows();
      end else if (track) begin
         if (err) begin
            if (err_run != bvm_pkg::CNT_MAX) err_run++;
         end else begin
            err_run = '0;
         end
         if (lp) begin
            cell0_total = cell0_total + c0 - cell0_win[slot];
            cell1_total = cell1_total + c1 - cell1_win[slot];
            cell0_win[slot] = c0;
            cell1_win[slot] = c1;
            slot = (slot + 1) % DEPTH;
         end
      end
      limit = low_mv * DEPTH;
      want.low_voltage = lp && (cell0_total < limit || cell1_total < limit);
      // count+1 formed wide so a full counter still meets the threshold
      want.in_error    = track && ((int'(err_run) + 1) >= int'(err_thr));
      want.error_count = err_run;
      want.cell0_sum   = (cell0_total > 32'(bvm_pkg::SUM_OUT_MAX)) ?
                         bvm_pkg::SUM_OUT_MAX : cell0_total[bvm_pkg::SUM_OUT_W-1:0];
      want.cell1_sum   = (cell1_total > 32'(bvm_pkg::SUM_OUT_MAX)) ?
                         bvm_pkg::SUM_OUT_MAX : cell1_total[bvm_pkg::SUM_OUT_W-1:0];
      expected_status_q.push_back(want);
   endfunction

   function void compare_field(string name, logic [bvm_pkg::CNT_W-1:0] want,
                               logic [bvm_pkg::CNT_W-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function void check_response(battery_status_type got);
      battery_status_type want;
      if (expected_status_q.size() == 0) begin
         failures++;
         $display("%0t: unexpected response, expected none, actual %h", $time, got);
         return;
      end
      want = expected_status_q.pop_front();
      compare_field("low_voltage", want.low_voltage, got.low_voltage);
      compare_field("in_error", want.in_error, got.in_error);
      compare_field("error_count", want.error_count, got.error_count);
      compare_field("cell0_sum", want.cell0_sum, got.cell0_sum);
      compare_field("cell1_sum", want.cell1_sum, got.cell1_sum);
   endfunction
endclass

module battery_low_voltage_monitor_test;
   import bvm_pkg::*;

   localparam int WINDOW_DEPTH = 4;
   localparam int NOMINAL_MV   = 3800;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [CELL_W-1:0]      req_cell0_mv;
   logic [CELL_W-1:0]      req_cell1_mv;
   logic                   req_sample_error;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_low_voltage;
   logic                   rsp_in_error;
   logic [CNT_W-1:0]       rsp_error_count;
   logic [SUM_OUT_W-1:0]   rsp_cell0_sum;
   logic [SUM_OUT_W-1:0]   rsp_cell1_sum;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   battery_scoreboard #(WINDOW_DEPTH, NOMINAL_MV) board;
   bit calm;            // no random idling on either side while set
   bit hold_request;    // asks the response side for one long hold-off

   battery_low_voltage_monitor #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .NOMINAL_MV(NOMINAL_MV)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_cell0_mv(req_cell0_mv),
      .req_cell1_mv(req_cell1_mv),
      .req_sample_error(req_sample_error),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_low_voltage(rsp_low_voltage),
      .rsp_in_error(rsp_in_error),
      .rsp_error_count(rsp_error_count),
      .rsp_cell0_sum(rsp_cell0_sum),
      .rsp_cell1_sum(rsp_cell1_sum),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic send_request(input logic kind, input logic [CELL_W-1:0] c0,
                               input logic [CELL_W-1:0] c1, input logic err);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_cell0_mv     <= c0;
      req_cell1_mv     <= c1;
      req_sample_error <= err;
      do @(posedge clock); while (req_stall);
      board.note_sample(kind, c0, c1, err);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, data);
   endtask

   task automatic apply_settings(input logic te, input logic lpe,
                                 input logic [CELL_W-1:0] low, input logic [ERR_THR_W-1:0] thr);
      wait_drained();
      write_register(CSR_TRACKING_ENABLE, CSR_DATA_W'(te));
      write_register(CSR_LOW_POWER_ENABLE, CSR_DATA_W'(lpe));
      write_register(CSR_LOW_THRESHOLD_MV, CSR_DATA_W'(low));
      write_register(CSR_ERROR_THRESHOLD, CSR_DATA_W'(thr));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CELL_W-1:0] cell_near(input logic [CELL_W-1:0] center);
      int v;
      v = int'(center) + int'($urandom_range(600)) - 300;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      return CELL_W'(v);
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin : response_side
      int                 hold_left;
      battery_status_type got;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.low_voltage = rsp_low_voltage;
            got.in_error    = rsp_in_error;
            got.error_count = rsp_error_count;
            got.cell0_sum   = rsp_cell0_sum;
            got.cell1_sum   = rsp_cell1_sum;
            board.check_response(got);
         end
         if (hold_request) begin
            hold_left    = 60;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 19);
         end
      end
   end

   initial begin : stimulus
      logic [CELL_W-1:0]    low;
      logic                 streak;
      logic                 kind;
      logic [CELL_W-1:0]    c0;
      logic [CELL_W-1:0]    c1;
      board            = new();
      calm             = 1'b0;
      hold_request     = 1'b0;
      streak           = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_SAMPLE;
      req_cell0_mv     <= '0;
      req_cell1_mv     <= '0;
      req_sample_error <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_TRACKING_ENABLE;
      csr_data         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tracking off out of reset: nothing moves, flags stay low
      send_request(KIND_SAMPLE, 13'd8191, 13'd8191, 1'b1);
      send_request(KIND_RESTART, 13'd0, 13'd0, 1'b0);

      apply_settings(1'b1, 1'b1, 13'd3300, 4'd3);
      send_request(KIND_SAMPLE, 13'd0, 13'd0, 1'b1);
      send_request(KIND_SAMPLE, 13'd8191, 13'd8191, 1'b1);
      send_request(KIND_SAMPLE, 13'd8191, 13'd0, 1'b1);
      send_request(KIND_SAMPLE, 13'd0, 13'd8191, 1'b0);
      // restart ignores its payload
      send_request(KIND_RESTART, 13'd8191, 13'd8191, 1'b1);
      send_request(KIND_SAMPLE, 13'd1, 13'd1, 1'b1);

      // zero error threshold flags whenever tracking is on
      apply_settings(1'b1, 1'b1, 13'd0, 4'd0);
      send_request(KIND_SAMPLE, 13'd0, 13'd0, 1'b0);
      send_request(KIND_SAMPLE, 13'd8191, 13'd8191, 1'b1);

      apply_settings(1'b1, 1'b1, 13'd8191, 4'd15);
      send_request(KIND_SAMPLE, 13'd8191, 13'd8191, 1'b1);
      send_request(KIND_SAMPLE, 13'd8191, 13'd8191, 1'b1);
      send_request(KIND_RESTART, 13'd0, 13'd0, 1'b0);

      // low power off: only the error counter moves, restart does nothing
      apply_settings(1'b1, 1'b0, 13'd3300, 4'd2);
      send_request(KIND_SAMPLE, 13'd100, 13'd100, 1'b1);
      send_request(KIND_RESTART, 13'd0, 13'd0, 1'b0);
      send_request(KIND_SAMPLE, 13'd0, 13'd0, 1'b0);

      apply_settings(1'b0, 1'b1, 13'd3300, 4'd1);
      send_request(KIND_SAMPLE, 13'd4000, 13'd4000, 1'b1);
      send_request(KIND_RESTART, 13'd0, 13'd0, 1'b0);

      // long error run well past the largest threshold
      apply_settings(1'b1, 1'b1, 13'd3500, 4'd15);
      calm = 1'b1;
      for (int n = 0; n < 40; n++)
         send_request(KIND_SAMPLE, CELL_W'($urandom), CELL_W'($urandom), 1'b1);
      send_request(KIND_SAMPLE, 13'd3800, 13'd3800, 1'b0);
      calm = 1'b0;

      for (int seg = 0; seg < 8; seg++) begin
         case ($urandom_range(5))
            0:       low = 13'd0;
            1:       low = 13'd8191;
            default: low = CELL_W'($urandom_range(2500, 4500));
         endcase
         apply_settings($urandom_range(9) != 0, $urandom_range(4) != 0, low,
                        ERR_THR_W'($urandom_range(15)));
         calm = (seg == 2) || (seg == 4);
         // fill the block while the response side holds off
         if (seg == 4) hold_request = 1'b1;
         for (int n = 0; n < 100; n++) begin
            if (seg == 6 && n == 50) wait_drained();
            if ($urandom_range(99) < 15) streak = !streak;
            kind = ($urandom_range(99) < 6) ? KIND_RESTART : KIND_SAMPLE;
            c0 = ($urandom_range(3) == 0) ? CELL_W'($urandom) : cell_near(low);
            c1 = ($urandom_range(3) == 0) ? CELL_W'($urandom) : cell_near(low);
            send_request(kind, c0, c1, streak);
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (4) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
